// File: src/i2csbm_pkg.sv
package i2csbm_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned WAIT_W  = 8;
    localparam int unsigned BITC_W  = 4;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ACK_WAIT_LIMIT = 2'd1;

    localparam logic [ADDR_W-1:0] DEV_ADDR_RST   = 7'd47;
    localparam logic [WAIT_W-1:0] ACK_LIMIT_RST  = 8'd250;

    // phase lengths in ticks
    localparam logic [WAIT_W-1:0] START_TICKS = 8'd4;
    localparam logic [WAIT_W-1:0] BIT_TICKS   = 8'd2;
    localparam logic [WAIT_W-1:0] RX_LO_TICKS = 8'd2;
    localparam logic [WAIT_W-1:0] NACK_TICKS  = 8'd2;
    localparam logic [WAIT_W-1:0] STOP_TICKS  = 8'd4;

    localparam logic [BITC_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [16:0] {
        PH_IDLE     = 17'h00001,
        PH_START_HI = 17'h00002,
        PH_START_LO = 17'h00004,
        PH_TX_SET   = 17'h00008,
        PH_TX_HIGH  = 17'h00010,
        PH_TX_LOW   = 17'h00020,
        PH_ACK_LO   = 17'h00040,
        PH_ACK_HI   = 17'h00080,
        PH_ACK_POLL = 17'h00100,
        PH_RX_LO    = 17'h00200,
        PH_RX_HI    = 17'h00400,
        PH_NACK_LO  = 17'h00800,
        PH_NACK_HI  = 17'h01000,
        PH_STOP_LO  = 17'h02000,
        PH_STOP_HI  = 17'h04000,
        PH_ESTOP_LO = 17'h08000,
        PH_ESTOP_HI = 17'h10000
    } t_phase;

endpackage

// File: src/i2c_single_byte_master.sv
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+--------------------------------------
// in       | input     | i_in_valid / o_in_ready       | i_kind, i_write_value, i_sda_in
// out      | output    | o_out_valid / i_out_ready     | o_scl_level, o_sda_level,
//          |           |                               | o_sda_released, o_busy_res,
//          |           |                               | o_done_res, o_ack_missing, o_read_value
// cfg      | input     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One request (one tick) per cycle while the output drains: the sequencer step is a single
// pass from the state registers to the result register, so the result shows in the next cycle.
// A single output register parts the channels; o_in_ready is high while it is empty
// or being drained, so a stalled consumer stalls the input after one result.
// Reset (synchronous, active low): idle phase, SCL/SDA high, registers to defaults.
// Config writes are always taken (o_cfg_ready tied high).
module i2c_single_byte_master (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tick request
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [i2csbm_pkg::KIND_W-1:0]    i_kind,
    input  logic [i2csbm_pkg::BYTE_W-1:0]    i_write_value,
    input  logic                             i_sda_in,
    // result
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_scl_level,
    output logic                             o_sda_level,
    output logic                             o_sda_released,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic                             o_ack_missing,
    output logic [i2csbm_pkg::BYTE_W-1:0]    o_read_value,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [i2csbm_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [i2csbm_pkg::BYTE_W-1:0]    i_cfg_data
);
    import i2csbm_pkg::*;

    // config registers
    logic [ADDR_W-1:0] r_dev_addr;
    logic [WAIT_W-1:0] r_ack_limit;

    // sequencer state
    t_phase            r_phase, s_phase, n_phase;
    logic [WAIT_W-1:0] r_wait,  s_wait,  n_wait;
    logic [BITC_W-1:0] r_bit,   s_bit,   n_bit;
    logic [BYTE_W-1:0] r_shift, s_shift, n_shift;
    logic [BYTE_W-1:0] r_pending, s_pending;
    logic              r_is_read, s_is_read;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic [BYTE_W-1:0] r_last, n_last;

    // per-tick flags
    logic              n_released, n_done, n_missing;

    // output stage
    logic              r_out_valid;
    logic              r_o_released, r_o_busy, r_o_done, r_o_missing;

    logic              in_acc;
    logic [WAIT_W-1:0] wait_inc;
    logic [BITC_W-1:0] bit_inc;
    logic [BYTE_W-1:0] rx_shift;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // command decode: a start request is only honored from idle
    always_comb begin
        s_phase   = r_phase;
        s_wait    = r_wait;
        s_bit     = r_bit;
        s_shift   = r_shift;
        s_pending = r_pending;
        s_is_read = r_is_read;
        if (r_phase == PH_IDLE && (i_kind == KIND_WRITE || i_kind == KIND_READ)) begin
            s_is_read = (i_kind == KIND_READ);
            s_pending = i_write_value;
            s_shift   = {r_dev_addr, (i_kind == KIND_READ)};
            s_bit     = '0;
            s_wait    = '0;
            s_phase   = PH_START_HI;
        end
    end

    assign wait_inc = s_wait + 8'd1;
    assign bit_inc  = s_bit + 4'd1;
    assign rx_shift = {s_shift[BYTE_W-2:0], i_sda_in};

    // one tick of the bus sequencer
    always_comb begin
        n_phase    = s_phase;
        n_wait     = wait_inc;
        n_bit      = s_bit;
        n_shift    = s_shift;
        n_scl      = 1'b1;
        n_sda      = 1'b1;
        n_last     = r_last;
        n_released = 1'b0;
        n_done     = 1'b0;
        n_missing  = 1'b0;
        unique case (s_phase)
            PH_START_HI: begin
                if (wait_inc >= START_TICKS) begin
                    n_phase = PH_START_LO;
                    n_wait  = '0;
                end
            end
            PH_START_LO: begin
                n_sda = 1'b0;
                if (wait_inc >= START_TICKS) begin
                    n_phase = PH_TX_SET;
                    n_wait  = '0;
                end
            end
            PH_TX_SET: begin
                n_scl = 1'b0;
                n_sda = s_shift[BYTE_W-1];
                if (wait_inc >= BIT_TICKS) begin
                    n_phase = PH_TX_HIGH;
                    n_wait  = '0;
                end
            end
            PH_TX_HIGH: begin
                n_sda = s_shift[BYTE_W-1];
                if (wait_inc >= BIT_TICKS) begin
                    n_phase = PH_TX_LOW;
                    n_wait  = '0;
                end
            end
            PH_TX_LOW: begin
                n_scl = 1'b0;
                n_sda = s_shift[BYTE_W-1];
                if (wait_inc >= BIT_TICKS) begin
                    n_shift = {s_shift[BYTE_W-2:0], 1'b0};
                    n_bit   = bit_inc;
                    // byte boundary: address byte ends at 8, data byte wraps to 0
                    n_phase = (bit_inc[2:0] == 3'd0) ? PH_ACK_LO : PH_TX_SET;
                    n_wait  = '0;
                end
            end
            PH_ACK_LO: begin
                n_scl      = 1'b0;
                n_released = 1'b1;
                n_phase    = PH_ACK_HI;
                n_wait     = '0;
            end
            PH_ACK_HI: begin
                n_released = 1'b1;
                n_phase    = PH_ACK_POLL;
                n_wait     = '0;
            end
            PH_ACK_POLL: begin
                n_released = 1'b1;
                if (!i_sda_in) begin
                    n_wait = '0;
                    if (s_is_read) begin
                        n_bit   = '0;
                        n_shift = '0;
                        n_phase = PH_RX_LO;
                    end else if (s_bit == BITS_PER_BYTE) begin
                        n_shift = s_pending;
                        n_phase = PH_TX_SET;
                    end else begin
                        n_phase = PH_STOP_LO;
                    end
                end else if (s_wait >= r_ack_limit) begin
                    // no acknowledge: abort into stop
                    n_phase = PH_ESTOP_LO;
                    n_wait  = '0;
                end
            end
            PH_RX_LO: begin
                n_scl      = 1'b0;
                n_released = 1'b1;
                if (wait_inc >= RX_LO_TICKS) begin
                    n_phase = PH_RX_HI;
                    n_wait  = '0;
                end
            end
            PH_RX_HI: begin
                n_released = 1'b1;
                n_shift    = rx_shift;
                n_bit      = bit_inc;
                n_wait     = '0;
                if (bit_inc >= BITS_PER_BYTE) begin
                    n_last  = rx_shift;
                    n_phase = PH_NACK_LO;
                end else begin
                    n_phase = PH_RX_LO;
                end
            end
            PH_NACK_LO: begin
                n_scl = 1'b0;
                if (wait_inc >= NACK_TICKS) begin
                    n_phase = PH_NACK_HI;
                    n_wait  = '0;
                end
            end
            PH_NACK_HI: begin
                if (wait_inc >= NACK_TICKS) begin
                    n_phase = PH_STOP_LO;
                    n_wait  = '0;
                end
            end
            PH_STOP_LO, PH_ESTOP_LO: begin
                n_scl = 1'b0;
                n_sda = 1'b0;
                if (wait_inc >= STOP_TICKS) begin
                    n_phase = (s_phase == PH_STOP_LO) ? PH_STOP_HI : PH_ESTOP_HI;
                    n_wait  = '0;
                end
            end
            PH_STOP_HI, PH_ESTOP_HI: begin
                if (wait_inc >= STOP_TICKS) begin
                    n_done    = 1'b1;
                    n_missing = (s_phase == PH_ESTOP_HI);
                    n_phase   = PH_IDLE;
                    n_wait    = '0;
                end
            end
            default: begin
                // idle
                n_phase = PH_IDLE;
                n_wait  = '0;
            end
        endcase
    end

    // state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr  <= DEV_ADDR_RST;
            r_ack_limit <= ACK_LIMIT_RST;
            r_phase     <= PH_IDLE;
            r_wait      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_pending   <= '0;
            r_is_read   <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DEVICE_ADDRESS) begin
                    r_dev_addr <= i_cfg_data[ADDR_W-1:0];
                end else if (i_cfg_index == CFG_ACK_WAIT_LIMIT) begin
                    r_ack_limit <= i_cfg_data;
                end
            end
            if (in_acc) begin
                r_phase   <= n_phase;
                r_wait    <= n_wait;
                r_bit     <= n_bit;
                r_shift   <= n_shift;
                r_pending <= s_pending;
                r_is_read <= s_is_read;
                r_scl     <= n_scl;
                r_sda     <= n_sda;
                r_last    <= n_last;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_o_released <= n_released;
            r_o_busy     <= (n_phase != PH_IDLE);
            r_o_done     <= n_done;
            r_o_missing  <= n_missing;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_scl;
    assign o_sda_level    = r_sda;
    assign o_sda_released = r_o_released;
    assign o_busy_res     = r_o_busy;
    assign o_done_res     = r_o_done;
    assign o_ack_missing  = r_o_missing;
    assign o_read_value   = r_last;

    // checks
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register not one-hot");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while busy");

    a_missing_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_missing |-> o_done_res)
        else $error("ack_missing without done");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sda_released |-> o_sda_level)
        else $error("SDA driven low while released");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_phase == PH_IDLE && (i_kind == KIND_WRITE || i_kind == KIND_READ)
        |=> r_phase == PH_START_HI && r_wait == 8'd1 && o_busy_res)
        else $error("start request not taken from idle");

endmodule
